// File: src/bc_pkg.sv
// Shared widths and limits for the binomial coefficient block.
// Used by the channel interfaces and by the top level; depends on nothing.
package bc_pkg;

  localparam int MAX_N  = 33;
  localparam int N_W    = 6;   // width of n_value and r_value
  localparam int COEF_W = 31;  // width of the coefficient
  localparam int ACC_W  = 36;  // running product, C(n,i)*(n-i) stays below 2^36
  localparam int K_W    = 5;   // step count, min(r, n-r) is at most 16
  localparam int REM_W  = 5;   // divider remainder, below the divisor
  localparam int CNT_W  = 6;   // counts multiplier and divider iterations

endpackage

// File: src/bc_if.sv
// Valid/ready channels of the binomial coefficient block: request and response.
// Depends on bc_pkg for the field widths.
interface bc_req_if import bc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [N_W-1:0] n_value;
  logic [N_W-1:0] r_value;

  modport source (output valid, n_value, r_value, input ready);
  modport sink   (input valid, n_value, r_value, output ready);
endinterface

interface bc_rsp_if import bc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;
  logic              valid_res;

  modport source (output valid, coefficient, valid_res, input ready);
  modport sink   (input valid, coefficient, valid_res, output ready);
endinterface

// File: src/binomial_coefficient.sv
// Binomial coefficient C(n, r) by the multiplicative formula.
// Depends on bc_pkg and on the channel interfaces in bc_if.sv.
//
// Usage:
//   req carries n_value and r_value; rsp returns coefficient and valid_res.
//   Both are valid/ready channels; an item moves when valid and ready are high.
//   r is replaced by k = min(r, n-r). Each of the k steps multiplies the
//   running product by (n-i) with a shift-add multiplier, then divides it
//   exactly by (i+1) with a radix-2 restoring divider. n or r out of range,
//   or k = 0, skip the steps and go straight to the done state. The
//   multiply/divide sequencer takes no new item until the last one has left
//   it; req.ready is high only while it is idle.
//   If n exceeds MAX_N or r exceeds n, coefficient is 0 and valid_res is 0.
//   A finished result sits in the output register; a new item is accepted
//   while it waits. If the receiver stalls, the next finished result waits
//   in the sequencer until the output register frees.
//   Reset (rst, synchronous) empties the output register and idles the
//   sequencer; no memory needs clearing.
module binomial_coefficient import bc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bc_req_if.sink   req,
  bc_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state;
  logic [N_W-1:0]   nreg;
  logic [K_W-1:0]   k;
  logic [K_W-1:0]   i;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] prod;
  logic [N_W-1:0]   m;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             vres;

  logic              ovalid;
  logic [COEF_W-1:0] ocoef;
  logic              ores;

  // request decode
  logic [N_W-1:0] n_minus_r;
  logic           bad_req;
  logic [K_W-1:0] k_in;

  // multiplier and divider arithmetic
  logic [ACC_W-1:0] prod_next;
  logic [K_W:0]     divisor;
  logic [REM_W:0]   trial;
  logic             ge;
  logic [REM_W:0]   diff;
  logic [K_W-1:0]   i_inc;

  assign n_minus_r = req.n_value - req.r_value;
  assign bad_req   = (req.n_value > N_W'(MAX_N)) || (req.r_value > req.n_value);
  assign k_in      = (req.r_value <= n_minus_r) ? req.r_value[K_W-1:0]
                                                : n_minus_r[K_W-1:0];

  assign prod_next = m[0] ? prod + acc : prod;
  assign i_inc     = i + K_W'(1);
  assign divisor   = {1'b0, i} + (K_W+1)'(1);
  assign trial     = {rem, acc[ACC_W-1]};
  assign ge        = trial >= divisor;
  assign diff      = trial - divisor;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = ovalid;
  assign rsp.coefficient = ocoef;
  assign rsp.valid_res   = ores;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          nreg <= req.n_value;
          k    <= k_in;
          i    <= '0;
          prod <= '0;
          cnt  <= '0;
          m    <= req.n_value;
          if (bad_req) begin
            acc  <= '0;
            vres <= 1'b0;
          end else begin
            acc  <= ACC_W'(1);
            vres <= 1'b1;
          end
        end
      end
      S_MUL: begin
        m <= m >> 1;
        if (cnt == CNT_W'(N_W-1)) begin
          acc <= prod_next;
          rem <= '0;
          cnt <= '0;
        end else begin
          acc  <= acc << 1;
          prod <= prod_next;
          cnt  <= cnt + CNT_W'(1);
        end
      end
      S_DIV: begin
        rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        acc <= {acc[ACC_W-2:0], ge};
        if (cnt == CNT_W'(ACC_W-1)) begin
          i    <= i_inc;
          cnt  <= '0;
          prod <= '0;
          m    <= nreg - {1'b0, i_inc};
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (state == S_DONE && (!ovalid || rsp.ready)) begin
      ocoef <= acc[COEF_W-1:0];
      ores  <= vres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= (bad_req || k_in == '0) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == CNT_W'(N_W-1)) state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CNT_W'(ACC_W-1)) state <= (i_inc == k) ? S_DONE : S_MUL;
        end
        S_DONE: begin
          if (!ovalid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (state == S_DONE && (!ovalid || rsp.ready)) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // divider remainder always stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt != '0) |-> ({1'b0, rem} < divisor))
    else $error("divider remainder not below divisor");

  // step index never passes the step count while working
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DIV) |-> (i < k))
    else $error("step index beyond step count");

  // a finished valid product fits the coefficient width
  a_fit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && vres) |-> (acc[ACC_W-1:COEF_W] == '0))
    else $error("coefficient overflows its field");

  // an out-of-range request reports zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.valid_res) |-> (rsp.coefficient == '0))
    else $error("invalid result with nonzero coefficient");

  // accepted item leaves the sequencer busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("sequencer idle right after accept");

endmodule

// File: tb/sv/tb_binomial_coefficient.sv
// Self-checking bench for binomial_coefficient: C(n, r) over valid/ready channels.
// Uses bc_pkg widths and the bc_req_if / bc_rsp_if channels; predicts each item locally.
module tb_binomial_coefficient;
  import bc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [N_W-1:0] n_value;
    logic [N_W-1:0] r_value;
    bit             drain;    // hold off until every earlier result has come back
  } binom_req_t;

  typedef struct {
    logic [COEF_W-1:0] coefficient;
    logic              valid_res;
  } binom_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bc_req_if req_ch ();
  bc_rsp_if rsp_ch ();

  binomial_coefficient dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  binom_req_t todo_q[$];
  binom_t     coef_q[$];

  int sent_cnt    = 0;
  int got_cnt     = 0;
  int bad_range   = 0;
  int err_cnt     = 0;
  int hold_cnt    = 0;
  bit hold_done   = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic binom_t calc_binomial(logic [N_W-1:0] n, logic [N_W-1:0] r);
    binom_t          res;
    longint unsigned nn, rr, k, acc, i;
    nn = n;
    rr = r;
    acc = 1;
    res.coefficient = '0;
    res.valid_res   = 1'b0;
    if (nn <= MAX_N && rr <= nn) begin
      k = (rr > nn - rr) ? nn - rr : rr;
      for (i = 0; i < k; i++) begin
        acc = acc * (nn - i);
        acc = acc / (i + 1);
      end
      res.coefficient = acc[COEF_W-1:0];
      res.valid_res   = 1'b1;
    end
    return res;
  endfunction

  function automatic bit idle_now(int cnt);
    // no idling at all over a stretch in the middle of the run
    if (cnt >= 400 && cnt < 550) return 1'b0;
    return $urandom_range(99) < 32;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.n_value <= '0;
      req_ch.r_value <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        coef_q.push_back(calc_binomial(req_ch.n_value, req_ch.r_value));
        sent_cnt++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (todo_q.size() != 0 && !(todo_q[0].drain && coef_q.size() != 0) &&
            !idle_now(sent_cnt)) begin
          req_ch.n_value <= todo_q[0].n_value;
          req_ch.r_value <= todo_q[0].r_value;
          req_ch.valid   <= 1'b1;
          void'(todo_q.pop_front());
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long back-pressure window so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst && !hold_done && got_cnt >= 200) begin
      hold_done <= 1'b1;
      hold_cnt  <= 3000;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_cnt++;
        if (coef_q.size() == 0) begin
          $error("unexpected item: coefficient %0d valid_res %0d",
                 rsp_ch.coefficient, rsp_ch.valid_res);
          err_cnt++;
        end else begin
          if (rsp_ch.coefficient !== coef_q[0].coefficient) begin
            $error("coefficient: expected %0d, actual %0d",
                   coef_q[0].coefficient, rsp_ch.coefficient);
            err_cnt++;
          end
          if (rsp_ch.valid_res !== coef_q[0].valid_res) begin
            $error("valid_res: expected %0d, actual %0d",
                   coef_q[0].valid_res, rsp_ch.valid_res);
            err_cnt++;
          end
          if (!coef_q[0].valid_res) bad_range++;
          void'(coef_q.pop_front());
        end
      end
      if (hold_cnt > 0) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !idle_now(got_cnt);
      end
    end
  end

  task automatic add_item(int n, int r, bit drain = 1'b0);
    binom_req_t it;
    it.n_value = n[N_W-1:0];
    it.r_value = r[N_W-1:0];
    it.drain   = drain;
    todo_q.push_back(it);
  endtask

  initial begin
    int sel, n, r;

    // directed: edges of both fields, symmetry, r above n, n above the bound
    add_item(0, 0);
    add_item(1, 0);
    add_item(1, 1);
    add_item(2, 1);
    add_item(33, 0);
    add_item(33, 33);
    add_item(33, 16);
    add_item(33, 17);
    add_item(32, 16);
    add_item(33, 1);
    add_item(33, 32);
    add_item(10, 3);
    add_item(10, 7);
    add_item(5, 6);
    add_item(33, 34);
    add_item(0, 1);
    add_item(0, 63);
    add_item(34, 0);
    add_item(34, 34);
    add_item(63, 63);
    add_item(63, 0);
    add_item(63, 1);
    add_item(21, 42);

    for (int i = 0; i < 1000; i++) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        n = $urandom_range(63);
        r = $urandom_range(63);
      end else if (sel < 22) begin
        n = $urandom_range(32);
        r = $urandom_range(63, n + 1);
      end else begin
        n = $urandom_range(MAX_N);
        r = $urandom_range(n);
      end
      add_item(n, r, i == 0 || i == 600);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (todo_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (coef_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);

    $display("sent %0d items, checked %0d results (%0d out of range)",
             sent_cnt, got_cnt, bad_range);
    $display("covered field extremes, r above n, n above %0d, and a long output stall",
             MAX_N);
    if (err_cnt == 0) begin
      $display("tb_binomial_coefficient: clean");
    end else begin
      $display("tb_binomial_coefficient: errors");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", coef_q.size());
    $display("tb_binomial_coefficient: errors");
    $finish;
  end

endmodule

// File: filelist.f
src/bc_pkg.sv
src/bc_if.sv
src/binomial_coefficient.sv
tb/sv/tb_binomial_coefficient.sv
